@@ rtl/core/bop_pkg.sv @@
// ----------------------------------------------------------------------------
// bop_pkg
// Shared types, constants and fixed-point helpers for the binomial pricer.
// ----------------------------------------------------------------------------
package bop_pkg;

  localparam int MAX_STEPS = 1024;
  localparam int NODE_AW   = $clog2(MAX_STEPS + 1);

  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [30:0] Q30_HALF = 31'h2000_0000;

  localparam logic [NODE_AW-1:0] STEPS_MAX = NODE_AW'(MAX_STEPS);
  localparam logic [NODE_AW-1:0] STEPS_RST = NODE_AW'(256);

  typedef enum logic [2:0] {
    REG_UP_FACTOR   = 3'd0,
    REG_DOWN_FACTOR = 3'd1,
    REG_UP_PROB     = 3'd2,
    REG_DISCOUNT    = 3'd3,
    REG_STEP_COUNT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } mul_res_t;

  // Q16.16 x Q2.30 product: round half up, drop 30 bits, clip to 32 bits
  function automatic mul_res_t mul_round(input logic [63:0] prod);
    logic [63:0] r;
    mul_res_t    res;
    r       = prod + 64'(Q30_HALF);
    res.sat = |r[63:62];
    res.val = res.sat ? 32'hFFFF_FFFF : r[61:30];
    return res;
  endfunction

  function automatic logic [31:0] payoff(input logic [31:0] price,
                                         input logic [31:0] strike,
                                         input logic        put);
    logic [31:0] res;
    if (put) begin
      res = (strike > price) ? strike - price : 32'd0;
    end else begin
      res = (price > strike) ? price - strike : 32'd0;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/binomial_option_pricer_top.sv @@
// ----------------------------------------------------------------------------
// binomial_option_pricer_top
// Cox-Ross-Rubinstein option pricer on two node memories and one multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Write the tree factors and the step count n over the cfg channel while
//   idle. Send one option per s_ transfer: tdata holds spot and strike,
//   tuser holds the put flag and the American flag. The root value comes
//   back on m_ with a saturation flag in tuser.
//   One option is priced at a time. All work goes through a single 32x32
//   multiplier, one product per cycle, and the node memories (one read and
//   one write port each). An option runs n multiplies by d, then n double
//   multiplies by u, then the backward sweep over every node of the tree.
//   s_tready is high only while no option is in work; a finished result
//   sits in the output register, so the next option can start while it
//   waits. If the receiver still holds off the previous result, the block
//   waits at the end of the sweep until the register frees up.
//   Reset (rst, synchronous) returns the registers to their defaults and
//   drops any option in work; the node memories need no clearing.
// ----------------------------------------------------------------------------
module binomial_option_pricer_top
  import bop_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] spot, [63:32] strike
  input  logic [1:0]  s_tuser,   // [0] is_put, [1] early_exercise
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] option_value
  output logic [0:0]  m_tuser    // [0] saturated
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DN_MUL, ST_DN_RND, ST_UP1, ST_UP2, ST_UP3, ST_UP4,
    ST_B_RD0, ST_B_RD1, ST_B_M0, ST_B_M1, ST_B_M2, ST_B_M3, ST_B_M4, ST_FIN
  } st_t;

  st_t state;

  logic [31:0]        up_factor;
  logic [30:0]        down_factor;
  logic [30:0]        up_probability;
  logic [30:0]        step_discount;
  logic [NODE_AW-1:0] step_count;

  logic [31:0]        price;
  logic [31:0]        strike;
  logic               put;
  logic               amer;
  logic               sat;
  logic [NODE_AW-1:0] n;
  logic [30:0]        p;
  logic [30:0]        q;
  logic [NODE_AW-1:0] k;
  logic [NODE_AW-1:0] i;
  logic [NODE_AW-1:0] s;
  logic [31:0]        v0;
  logic [31:0]        v1;
  logic [31:0]        pr;
  logic [31:0]        prn;
  logic [31:0]        bl;
  logic [31:0]        res;
  logic [63:0]        acc;
  logic [63:0]        prod;

  logic [31:0] mul_x;
  logic [31:0] mul_y;
  mul_res_t    rq;
  logic [31:0] ex;
  logic [31:0] vfin;
  logic [63:0] blend;

  logic [31:0]        val_mem   [0:MAX_STEPS];
  logic [31:0]        price_mem [0:MAX_STEPS];
  logic               mem_we;
  logic [NODE_AW-1:0] mem_waddr;
  logic [NODE_AW-1:0] mem_raddr;
  logic [31:0]        val_wdata;
  logic [31:0]        price_wdata;
  logic [31:0]        val_q;
  logic [31:0]        price_q;

  logic [NODE_AW-1:0] n_in;
  logic [30:0]        p_in;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  always_comb begin
    n_in = step_count;
    if (step_count == '0) begin
      n_in = NODE_AW'(1);
    end else if (step_count > STEPS_MAX) begin
      n_in = STEPS_MAX;
    end
    p_in = (up_probability > Q30_ONE) ? Q30_ONE : up_probability;
  end

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      ST_DN_MUL: begin mul_x = price; mul_y = {1'b0, down_factor};   end
      ST_UP1,
      ST_UP3:    begin mul_x = price; mul_y = up_factor;              end
      ST_B_M0:   begin mul_x = v0;    mul_y = {1'b0, p};              end
      ST_B_M1:   begin mul_x = v1;    mul_y = {1'b0, q};              end
      ST_B_M2:   begin mul_x = pr;    mul_y = {1'b0, down_factor};    end
      ST_B_M3:   begin mul_x = bl;    mul_y = {1'b0, step_discount};  end
      default:   begin mul_x = '0;    mul_y = '0;                     end
    endcase
  end

  assign rq    = mul_round(prod);
  assign ex    = payoff(prn, strike, put);
  assign vfin  = (amer && ex > rq.val) ? ex : rq.val;
  assign blend = acc + prod + 64'(Q30_HALF);

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = i;
    price_wdata = rq.val;
    val_wdata   = payoff(rq.val, strike, put);
    mem_raddr   = i;
    case (state)
      ST_DN_RND: begin
        mem_we    = (k == n - NODE_AW'(1));
        mem_waddr = n;
      end
      ST_UP4: begin
        mem_we = 1'b1;
      end
      ST_B_M4: begin
        mem_we      = 1'b1;
        price_wdata = prn;
        val_wdata   = vfin;
      end
      ST_B_RD1: begin
        mem_raddr = i + NODE_AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem[mem_waddr]   <= val_wdata;
      price_mem[mem_waddr] <= price_wdata;
    end
    val_q   <= val_mem[mem_raddr];
    price_q <= price_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_factor      <= {Q30_ONE[30], Q30_ONE} & 32'h4000_0000;
      down_factor    <= Q30_ONE;
      up_probability <= Q30_HALF;
      step_discount  <= Q30_ONE;
      step_count     <= STEPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UP_FACTOR:   up_factor      <= cfg_data;
        REG_DOWN_FACTOR: down_factor    <= cfg_data[30:0];
        REG_UP_PROB:     up_probability <= cfg_data[30:0];
        REG_DISCOUNT:    step_discount  <= cfg_data[30:0];
        REG_STEP_COUNT:  step_count     <= cfg_data[NODE_AW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            price  <= s_tdata[31:0];
            strike <= s_tdata[63:32];
            put    <= s_tuser[0];
            amer   <= s_tuser[1];
            sat    <= 1'b0;
            n      <= n_in;
            p      <= p_in;
            q      <= Q30_ONE - p_in;
            k      <= '0;
            state  <= ST_DN_MUL;
          end
        end
        ST_DN_MUL: state <= ST_DN_RND;
        ST_DN_RND: begin
          price <= rq.val;
          sat   <= sat | rq.sat;
          if (k == n - NODE_AW'(1)) begin
            i     <= n - NODE_AW'(1);
            state <= ST_UP1;
          end else begin
            k     <= k + NODE_AW'(1);
            state <= ST_DN_MUL;
          end
        end
        ST_UP1: state <= ST_UP2;
        ST_UP2: begin
          price <= rq.val;
          sat   <= sat | rq.sat;
          state <= ST_UP3;
        end
        ST_UP3: state <= ST_UP4;
        ST_UP4: begin
          price <= rq.val;
          sat   <= sat | rq.sat;
          if (i == '0) begin
            s     <= n - NODE_AW'(1);
            state <= ST_B_RD0;
          end else begin
            i     <= i - NODE_AW'(1);
            state <= ST_UP1;
          end
        end
        ST_B_RD0: state <= ST_B_RD1;
        ST_B_RD1: begin
          v0    <= val_q;
          pr    <= price_q;
          state <= ST_B_M0;
        end
        ST_B_M0: begin
          v1    <= val_q;
          state <= ST_B_M1;
        end
        ST_B_M1: begin
          acc   <= prod;
          state <= ST_B_M2;
        end
        ST_B_M2: begin
          bl    <= blend[61:30];
          state <= ST_B_M3;
        end
        ST_B_M3: begin
          prn   <= rq.val;
          sat   <= sat | rq.sat;
          state <= ST_B_M4;
        end
        ST_B_M4: begin
          sat <= sat | rq.sat;
          res <= vfin;
          if (i == s) begin
            i <= '0;
            if (s == '0) begin
              state <= ST_FIN;
            end else begin
              s     <= s - NODE_AW'(1);
              state <= ST_B_RD0;
            end
          end else begin
            i     <= i + NODE_AW'(1);
            state <= ST_B_RD0;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= res;
            m_tuser[0] <= sat;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_node_in_level: assert property (@(posedge clk) disable iff (rst)
    state == ST_B_M4 |-> i <= s)
    else $error("node index beyond current level");

  a_write_in_tree: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> mem_waddr <= n)
    else $error("node write beyond tree size");

  a_steps_clamped: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> (n != '0 && n <= STEPS_MAX))
    else $error("step count out of range in work");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FIN)
    else $error("result raised outside final state");
`endif

endmodule

@@ tb/tb_binomial_option_pricer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_option_pricer_top
// Prices options on the tree block and checks each root value and saturation
// flag against a fixed-point tree valuation kept inside this bench. Covers
// reset defaults, field extremes, call/put with European/American exercise,
// clipped factors, out-of-range step counts, random options under several
// tree settings, and output back-pressure.
// ----------------------------------------------------------------------------
module tb_binomial_option_pricer_top;
  import bop_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } quote_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] spot, [63:32] strike
  logic [1:0]  s_tuser = '0;   // [0] is_put, [1] early_exercise
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] option_value
  logic [0:0]  m_tuser;        // [0] saturated

  // tree settings mirrored from the register writes
  logic [31:0] up_q30 = 32'h4000_0000;
  logic [30:0] down_q30 = Q30_ONE;
  logic [30:0] prob_q30 = Q30_HALF;
  logic [30:0] disc_q30 = Q30_ONE;
  logic [10:0] n_steps = 11'd256;

  logic [31:0] tree_val [0:MAX_STEPS];
  logic [31:0] tree_px  [0:MAX_STEPS];

  quote_t      pending_quotes[$];
  int          fail_cnt = 0;
  int          options_sent = 0;
  int          quotes_seen = 0;
  int          sat_seen = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        rx_hold = 1'b0;

  binomial_option_pricer_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] scale_q30(input logic [31:0] a, input logic [31:0] f,
                                            inout logic sat);
    logic [63:0] prod;
    prod = ({32'd0, a} * {32'd0, f} + 64'(Q30_HALF)) >> 30;
    if (prod > 64'h0000_0000_FFFF_FFFF) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return prod[31:0];
  endfunction

  function automatic logic [31:0] exercise_value(input logic [31:0] px, input logic [31:0] k,
                                                 input logic put);
    if (put) return (k > px) ? k - px : 32'd0;
    return (px > k) ? px - k : 32'd0;
  endfunction

  function automatic quote_t price_option(input logic [31:0] spot, input logic [31:0] k,
                                          input logic put, input logic amer);
    quote_t      q;
    int          n;
    logic [31:0] p;
    logic [31:0] pq;
    logic [31:0] px;
    logic [31:0] v;
    logic [31:0] ex;
    logic [63:0] blend;
    q.sat = 1'b0;
    n = n_steps;
    if (n < 1) n = 1;
    if (n > MAX_STEPS) n = MAX_STEPS;
    p  = (prob_q30 > Q30_ONE) ? 32'(Q30_ONE) : 32'(prob_q30);
    pq = 32'(Q30_ONE) - p;
    px = spot;
    for (int j = 0; j < n; j++) px = scale_q30(px, 32'(down_q30), q.sat);
    tree_px[n] = px;
    for (int i = n - 1; i >= 0; i--) begin
      px = scale_q30(scale_q30(px, up_q30, q.sat), up_q30, q.sat);
      tree_px[i] = px;
    end
    for (int j = 0; j <= n; j++) tree_val[j] = exercise_value(tree_px[j], k, put);
    for (int s = n - 1; s >= 0; s--) begin
      for (int i = 0; i <= s; i++) begin
        tree_px[i] = scale_q30(tree_px[i], 32'(down_q30), q.sat);
        blend = {32'd0, p} * {32'd0, tree_val[i]} + {32'd0, pq} * {32'd0, tree_val[i+1]}
              + 64'(Q30_HALF);
        v = scale_q30(blend[61:30], 32'(disc_q30), q.sat);
        if (amer) begin
          ex = exercise_value(tree_px[i], k, put);
          if (ex > v) v = ex;
        end
        tree_val[i] = v;
      end
    end
    q.value = tree_val[0];
    return q;
  endfunction

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    quote_t want;
    if (!rst && m_tvalid && m_tready) begin
      quotes_seen++;
      if (m_tuser[0]) sat_seen++;
      if (pending_quotes.size() == 0) begin
        $display("%0t: unexpected result value=%h sat=%b", $time, m_tdata, m_tuser[0]);
        fail_cnt++;
      end else begin
        want = pending_quotes.pop_front();
        if (m_tdata !== want.value) begin
          $display("%0t: option_value expected %h actual %h", $time, want.value, m_tdata);
          fail_cnt++;
        end
        if (m_tuser[0] !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, m_tuser[0]);
          fail_cnt++;
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_UP_FACTOR:   up_q30   = data;
      REG_DOWN_FACTOR: down_q30 = data[30:0];
      REG_UP_PROB:     prob_q30 = data[30:0];
      REG_DISCOUNT:    disc_q30 = data[30:0];
      REG_STEP_COUNT:  n_steps  = data[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_tree(input logic [31:0] u, input logic [31:0] d, input logic [31:0] p,
                          input logic [31:0] disc, input logic [31:0] n);
    write_reg(REG_UP_FACTOR, u);
    write_reg(REG_DOWN_FACTOR, d);
    write_reg(REG_UP_PROB, p);
    write_reg(REG_DISCOUNT, disc);
    write_reg(REG_STEP_COUNT, n);
  endtask

  task automatic send_option(input logic [31:0] spot, input logic [31:0] k,
                             input logic put, input logic amer);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {k, spot};
    s_tuser  <= {amer, put};
    do @(posedge clk); while (!s_tready);
    pending_quotes.push_back(price_option(spot, k, put, amer));
    options_sent++;
  endtask

  // lower valid and wait for all results, so the block is idle
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_quotes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_price;
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'h0050_0000 + $urandom_range(32'h0028_0000);  // 80..120
      2: return $urandom_range(32'h0001_0000);
      default: return 32'hFFFF_FFFF - $urandom_range(32'h0001_0000);
    endcase
  endfunction

  task automatic random_tree(input int max_n);
    logic [31:0] u;
    u = 32'h4000_0000 + $urandom_range(32'h0800_0000);
    case ($urandom_range(7))
      0: u = $urandom;
      1: u = 32'hFFFF_FFFF;
      default: ;
    endcase
    set_tree(u, $urandom_range(32'h4000_0000) | ($urandom_range(1) << 30),
             ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4000_0000),
             ($urandom_range(3) == 0) ? $urandom : 32'h3F00_0000 + $urandom_range(32'h0100_0000),
             $urandom_range(max_n, 1));
  endtask

  task automatic test_reset_defaults;
    send_option(32'h0064_0000, 32'h0064_0000, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_field_extremes;
    set_tree(32'h4200_0000, 32'h3E00_0000, 32'h2100_0000, 32'h3FF0_0000, 2);
    send_option(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_option(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1);
    send_option(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_option(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    for (int f = 0; f < 4; f++) send_option(32'h0064_0000, 32'h005A_0000, f[0], f[1]);
    send_option(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1);
    send_option(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_special_cases;
    // probability above one, and full-scale up factor that saturates
    set_tree(32'hFFFF_FFFF, 32'h3000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3);
    send_option(32'h0064_0000, 32'h0032_0000, 1'b0, 1'b1);
    send_option(32'hFFFF_FFFF, 32'h0001_0000, 1'b1, 1'b0);
    drain();
    // zero down factor and zero discount, step count zero
    set_tree(32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
    send_option(32'h0064_0000, 32'h0032_0000, 1'b1, 1'b1);
    send_option(32'h0064_0000, 32'h0032_0000, 1'b0, 1'b0);
    drain();
    // tiny prices rounding to zero
    set_tree(32'h4000_0001, 32'h0000_0100, 32'h2000_0000, 32'h4000_0000, 5);
    send_option(32'h0000_0003, 32'h0000_0002, 1'b1, 1'b1);
    drain();
    // step count above the maximum: full-size tree
    set_tree(32'h4020_0000, 32'h3FE0_0000, 32'h2000_0000, 32'h3FFF_0000, 11'h7FF);
    send_option(32'h0064_0000, 32'h0064_0000, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_random(input int tx, input int rx, input int items);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    for (int j = 0; j < items; j++) begin
      if (j % 11 == 0) begin
        drain();
        random_tree(($urandom_range(9) == 0) ? 48 : 10);
      end
      send_option(rand_price(), rand_price(), $urandom_range(1), $urandom_range(1));
    end
    drain();
  endtask

  task automatic test_output_backpressure;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_tree(32'h4100_0000, 32'h3F00_0000, 32'h2000_0000, 32'h3FF8_0000, 2);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (3000) @(posedge clk);
        rx_hold <= 1'b0;
      end
      for (int j = 0; j < 4; j++)
        send_option(rand_price(), rand_price(), $urandom_range(1), $urandom_range(1));
    join
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_special_cases();
    test_random(18, 66, 27);
    test_random(66, 18, 27);
    test_random(0, 0, 26);
    test_output_backpressure();
    repeat (50) @(posedge clk);
    $display("Covered %0d options (%0d results, %0d saturated) over call/put, European/American,",
             options_sent, quotes_seen, sat_seen);
    $display("clipped factors, step counts 0..1024 and a long output hold-off.");
    if (fail_cnt == 0 && pending_quotes.size() == 0) begin
      $display("binomial_option_pricer_top test passed");
    end else begin
      $display("binomial_option_pricer_top test failed");
    end
    $finish;
  end

  initial begin
    #(64'd300_000_000);
    $display("binomial_option_pricer_top test failed");
    $finish;
  end

endmodule

@@ binomial_option_pricer_top.f @@
rtl/core/bop_pkg.sv
rtl/core/binomial_option_pricer_top.sv
tb/tb_binomial_option_pricer_top.sv
